[rtl/core/fhbc_pkg.sv]
`default_nettype none

package fhbc_pkg;

    localparam int DEF_MAX_LEN = 63;
    localparam int SLOT_BITS   = 16;
    localparam int FILL_W      = SLOT_BITS + 1;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_FLUSH  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_COMMIT = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_MISS   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OUT_SKIPPED  = 2'd0,
        OUT_STORED   = 2'd1,
        OUT_REPLACED = 2'd2,
        OUT_KEPT     = 2'd3
    } t_outcome;

    localparam logic [1:0] TIER_NONE = 2'd0;
    localparam logic [1:0] TIER_SOME = 2'd1;
    localparam logic [1:0] TIER_ALL  = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_APPEND2,
        ST_CMT_DEC,
        ST_COPY,
        ST_COPY_END,
        ST_EMIT_CMT,
        ST_LK_DEC,
        ST_EMIT_MISS,
        ST_LK_BYTE,
        ST_LK_WAIT
    } t_state;

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return is_lower(c) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic [15:0] fold(input logic [15:0] acc, input logic [7:0] c);
        logic [7:0] u;
        u = is_lower(c) ? (c - CASE_BIT) : c;
        return {acc[12:0], acc[15:13]} + {8'd0, u};
    endfunction

endpackage

`default_nettype wire

[rtl/core/fhbc_line.sv]
`default_nettype none

module fhbc_line
    import fhbc_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN,
    localparam int SW = $clog2(MAX_LEN + 1),
    localparam int LW = $clog2(MAX_LEN + 2)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_append,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_clear,
    input  wire logic [SW-1:0] i_rd_idx,
    output logic [7:0]         o_rd_byte,
    output logic [15:0]        o_hash,
    output logic [LW-1:0]      o_length,
    output logic [1:0]         o_tier
);

    logic [7:0]    r_buf [MAX_LEN];
    logic [7:0]    r_rd_q;
    logic [15:0]   r_acc;
    logic [LW-1:0] r_len;
    logic          r_all;
    logic          r_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc <= '0;
            r_len <= '0;
            r_all <= 1'b1;
            r_any <= 1'b0;
        end else if (i_append) begin
            r_acc <= fold(r_acc, i_byte);
            if (r_len <= LW'(MAX_LEN)) begin
                r_len <= r_len + 1'b1;
            end
            if (is_letter(i_byte)) begin
                r_any <= 1'b1;
            end else begin
                r_all <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_append && (r_len < LW'(MAX_LEN))) begin
            r_buf[r_len[SW-1:0]] <= i_byte;
        end
        r_rd_q <= r_buf[i_rd_idx];
    end

    assign o_rd_byte = r_rd_q;
    assign o_hash    = r_acc;
    assign o_length  = r_len;
    assign o_tier    = r_all ? TIER_ALL : (r_any ? TIER_SOME : TIER_NONE);

endmodule

`default_nettype wire

[rtl/core/fold_hash_best_candidate_table.sv]
`default_nettype none

// Reverse lookup table for a 16-bit folding hash of wordlist lines.
// Input channel: i_valid/o_stall carries an operation, a wordlist byte and a
// lookup value. Output channel: o_valid/i_stall carries commit reports,
// candidate bytes and lookup misses, each beat with a last flag.
// A wordlist byte causes no output beat; when a held carriage return is
// appended first, the block passes through ST_APPEND2 before the next input.
// A stored or replaced commit reads the slot and then copies the line byte by
// byte into it; a kept line is reported after the slot read, a skipped one directly.
// A lookup reads the slot, then emits each stored byte of the candidate byte
// memory through ST_LK_BYTE and ST_LK_WAIT, one byte at a time; a miss emits
// a single miss beat.
// After reset every entry of the slot length memory is swept to empty, one
// entry a cycle; o_stall stays high during that sweep.
// A result waits in the output register while i_stall is high, and the block
// holds its current operation until the output register is free for its next beat.
// Only one operation is in flight at a time, so no memory entry is read while
// an earlier write to it is still pending.

module fold_hash_best_candidate_table
    import fhbc_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_operation,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic [15:0]   i_lookup_value,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [1:0]         o_kind,
    output logic [1:0]         o_outcome,
    output logic [15:0]        o_hash_value,
    output logic [7:0]         o_out_byte,
    output logic               o_found,
    output logic               o_last,
    output logic [FILL_W-1:0]  o_filled_count
);

    localparam int SW = $clog2(MAX_LEN + 1);
    localparam int LW = $clog2(MAX_LEN + 2);
    localparam int MW = SW + 2;
    localparam int SLOTS = 1 << SLOT_BITS;

    t_state r_state, n_state;

    logic [MW-1:0] r_meta [SLOTS];
    logic [MW-1:0] r_meta_q;
    logic [7:0]    r_bytes [SLOTS << SW];
    logic [7:0]    r_byte_q;

    logic [SLOT_BITS-1:0] r_clr_addr;
    logic                 r_pending, n_pending;
    logic                 r_started, n_started;
    logic [7:0]           r_saved, n_saved;
    logic [15:0]          r_hash, n_hash;
    logic [LW-1:0]        r_len, n_len;
    logic [1:0]           r_tier, n_tier;
    t_outcome             r_outcome, n_outcome;
    logic [SW-1:0]        r_idx, n_idx;
    logic                 r_cp_v;
    logic [SW-1:0]        r_cp_idx;
    logic [FILL_W-1:0]    r_filled, n_filled;

    logic               r_o_valid, n_o_valid;
    t_kind              r_o_kind, n_o_kind;
    t_outcome           r_o_outcome, n_o_outcome;
    logic [15:0]        r_o_hash, n_o_hash;
    logic [7:0]         r_o_byte, n_o_byte;
    logic               r_o_found, n_o_found;
    logic               r_o_last, n_o_last;
    logic [FILL_W-1:0]  r_o_filled, n_o_filled;

    logic          accept;
    logic          out_free;
    t_op           op;
    logic          is_lf;
    logic          cmt_start;
    logic          line_ok;
    logic          ln_append;
    logic [7:0]    ln_byte;
    logic          ln_clear;
    logic [7:0]    ln_rd_byte;
    logic [15:0]   ln_hash;
    logic [LW-1:0] ln_len;
    logic [1:0]    ln_tier;

    logic [SLOT_BITS-1:0] meta_rd_addr;
    logic                 meta_we;
    logic [SLOT_BITS-1:0] meta_wr_addr;
    logic [MW-1:0]        meta_wr_data;
    logic [SW-1:0]        old_len;
    logic [1:0]           stored_tier;
    logic                 better;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign op       = t_op'(i_operation);
    assign is_lf    = (i_data_byte == CH_LF);
    assign cmt_start = ((op == OP_BYTE) && is_lf) || ((op == OP_FLUSH) && r_started);
    assign line_ok  = (ln_len != '0) && (ln_len <= LW'(MAX_LEN));
    assign old_len  = r_meta_q[SW-1:0];
    assign stored_tier = r_meta_q[MW-1:SW];
    assign better   = (r_tier > stored_tier) ||
                      ((r_tier == stored_tier) && (r_len < LW'(old_len)));

    fhbc_line #(
        .MAX_LEN(MAX_LEN)
    ) u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_append  (ln_append),
        .i_byte    (ln_byte),
        .i_clear   (ln_clear),
        .i_rd_idx  (r_idx),
        .o_rd_byte (ln_rd_byte),
        .o_hash    (ln_hash),
        .o_length  (ln_len),
        .o_tier    (ln_tier)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_BYTE: begin
                            if (is_lf) begin
                                n_state = line_ok ? ST_CMT_DEC : ST_EMIT_CMT;
                            end else if (r_pending && (i_data_byte != CH_CR)) begin
                                n_state = ST_APPEND2;
                            end
                        end
                        OP_FLUSH: begin
                            if (r_started) begin
                                n_state = line_ok ? ST_CMT_DEC : ST_EMIT_CMT;
                            end
                        end
                        OP_LOOKUP: n_state = ST_LK_DEC;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_APPEND2: n_state = ST_IDLE;
            ST_CMT_DEC: begin
                n_state = ((old_len == '0) || better) ? ST_COPY : ST_EMIT_CMT;
            end
            ST_COPY: begin
                if (LW'(r_idx) == r_len - 1'b1) begin
                    n_state = ST_COPY_END;
                end
            end
            ST_COPY_END: n_state = ST_EMIT_CMT;
            ST_EMIT_CMT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LK_DEC: begin
                n_state = (old_len == '0) ? ST_EMIT_MISS : ST_LK_BYTE;
            end
            ST_EMIT_MISS: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LK_BYTE: begin
                if (out_free) begin
                    n_state = ST_LK_WAIT;
                end
            end
            ST_LK_WAIT: begin
                n_state = (LW'(r_idx) == r_len - 1'b1) ? ST_IDLE : ST_LK_BYTE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        n_pending   = r_pending;
        n_started   = r_started;
        n_saved     = r_saved;
        n_hash      = r_hash;
        n_len       = r_len;
        n_tier      = r_tier;
        n_outcome   = r_outcome;
        n_idx       = r_idx;
        n_filled    = r_filled;
        n_o_valid   = r_o_valid && i_stall;
        n_o_kind    = r_o_kind;
        n_o_outcome = r_o_outcome;
        n_o_hash    = r_o_hash;
        n_o_byte    = r_o_byte;
        n_o_found   = r_o_found;
        n_o_last    = r_o_last;
        n_o_filled  = r_o_filled;
        ln_append   = 1'b0;
        ln_byte     = i_data_byte;
        ln_clear    = 1'b0;
        meta_rd_addr = (op == OP_LOOKUP) ? i_lookup_value : ln_hash;
        meta_we      = 1'b0;
        meta_wr_addr = r_hash;
        meta_wr_data = {r_tier, r_len[SW-1:0]};
        case (r_state)
            ST_CLEAR: begin
                meta_we      = 1'b1;
                meta_wr_addr = r_clr_addr;
                meta_wr_data = '0;
            end
            ST_IDLE: begin
                if (accept && cmt_start) begin
                    n_hash    = ln_hash;
                    n_len     = ln_len;
                    n_tier    = ln_tier;
                    n_outcome = OUT_SKIPPED;
                    n_pending = 1'b0;
                    n_started = 1'b0;
                    ln_clear  = 1'b1;
                end else if (accept && (op == OP_BYTE)) begin
                    n_started = 1'b1;
                    n_saved   = i_data_byte;
                    if (r_pending) begin
                        ln_append = 1'b1;
                        ln_byte   = CH_CR;
                        n_pending = (i_data_byte == CH_CR);
                    end else if (i_data_byte == CH_CR) begin
                        n_pending = 1'b1;
                    end else begin
                        ln_append = 1'b1;
                    end
                end else if (accept && (op == OP_LOOKUP)) begin
                    n_hash = i_lookup_value;
                end
            end
            ST_APPEND2: begin
                ln_append = 1'b1;
                ln_byte   = r_saved;
            end
            ST_CMT_DEC: begin
                n_idx = '0;
                if (old_len == '0) begin
                    n_outcome = OUT_STORED;
                    n_filled  = r_filled + 1'b1;
                    meta_we   = 1'b1;
                end else if (better) begin
                    n_outcome = OUT_REPLACED;
                    meta_we   = 1'b1;
                end else begin
                    n_outcome = OUT_KEPT;
                end
            end
            ST_COPY: n_idx = r_idx + 1'b1;
            ST_EMIT_CMT: begin
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_kind    = KIND_COMMIT;
                    n_o_outcome = r_outcome;
                    n_o_hash    = r_hash;
                    n_o_byte    = '0;
                    n_o_found   = 1'b0;
                    n_o_last    = 1'b1;
                    n_o_filled  = r_filled;
                end
            end
            ST_LK_DEC: begin
                n_idx = '0;
                n_len = LW'(old_len);
            end
            ST_EMIT_MISS: begin
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_kind    = KIND_MISS;
                    n_o_outcome = OUT_SKIPPED;
                    n_o_hash    = r_hash;
                    n_o_byte    = '0;
                    n_o_found   = 1'b0;
                    n_o_last    = 1'b1;
                    n_o_filled  = r_filled;
                end
            end
            ST_LK_WAIT: begin
                n_o_valid   = 1'b1;
                n_o_kind    = KIND_BYTE;
                n_o_outcome = OUT_SKIPPED;
                n_o_hash    = r_hash;
                n_o_byte    = r_byte_q;
                n_o_found   = 1'b1;
                n_o_last    = (LW'(r_idx) == r_len - 1'b1);
                n_o_filled  = r_filled;
                n_idx       = r_idx + 1'b1;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_pending  <= 1'b0;
            r_started  <= 1'b0;
            r_filled   <= '0;
            r_o_valid  <= 1'b0;
            r_cp_v     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= r_clr_addr + 1'b1;
            r_pending  <= n_pending;
            r_started  <= n_started;
            r_filled   <= n_filled;
            r_o_valid  <= n_o_valid;
            r_cp_v     <= (r_state == ST_COPY);
        end
    end

    always_ff @(posedge i_clk) begin
        r_saved     <= n_saved;
        r_hash      <= n_hash;
        r_len       <= n_len;
        r_tier      <= n_tier;
        r_outcome   <= n_outcome;
        r_idx       <= n_idx;
        r_cp_idx    <= r_idx;
        r_o_kind    <= n_o_kind;
        r_o_outcome <= n_o_outcome;
        r_o_hash    <= n_o_hash;
        r_o_byte    <= n_o_byte;
        r_o_found   <= n_o_found;
        r_o_last    <= n_o_last;
        r_o_filled  <= n_o_filled;
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta[meta_wr_addr] <= meta_wr_data;
        end
        r_meta_q <= r_meta[meta_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_cp_v) begin
            r_bytes[{r_hash, r_cp_idx}] <= ln_rd_byte;
        end
        r_byte_q <= r_bytes[{r_hash, r_idx}];
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_outcome      = r_o_outcome;
    assign o_hash_value   = r_o_hash;
    assign o_out_byte     = r_o_byte;
    assign o_found        = r_o_found;
    assign o_last         = r_o_last;
    assign o_filled_count = r_o_filled;

endmodule

`default_nettype wire
